// File: rtl/esdm_pkg.sv
// esdm_pkg: shared types and constants for the encoder speed and direction meter
// used by esdm_divider and encoder_speed_direction_meter; no dependencies
package esdm_pkg;

	localparam int NUM_W    = 37;   // speed numerator width
	localparam int DEN_W    = 32;   // timestamp and divisor width
	localparam int SPEED_W  = 32;
	localparam int CAP_W    = 16;
	localparam int CNT_W    = 16;
	localparam int STEP_W   = $clog2(NUM_W);
	localparam int CFG_W    = 64;
	localparam int ADDR_W   = 4;
	localparam int OUT_W    = 40;   // speed and direction, padded to bytes

	localparam logic [CNT_W-1:0] PERIOD_RST = 16'd1000;
	localparam logic [NUM_W-1:0] NUMER_RST  = 37'd86400000000;

	typedef enum logic [1:0] {
		KIND_OVF = 2'd0,
		KIND_A   = 2'd1,
		KIND_B   = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic {
		REG_PERIOD = 1'b0,
		REG_NUMER  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} main_state_t;

	typedef enum logic {
		DIV_IDLE,
		DIV_RUN
	} div_state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

endpackage

// File: rtl/esdm_divider.sv
// esdm_divider: restoring divider, one quotient bit per cycle, 32-bit saturated result
// depends on esdm_pkg
module esdm_divider import esdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done,
	output logic [SPEED_W-1:0] quotient
);

	div_state_t          state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic [NUM_W-1:0]    nq_q;
	logic [DEN_W-1:0]    rem_q;
	logic [DEN_W-1:0]    den_q;
	logic                done_q;
	logic [SPEED_W-1:0]  quot_q;

	logic [DEN_W:0]      rem_shift;
	logic [DEN_W:0]      diff;
	logic                ge;
	logic [DEN_W-1:0]    rem_next;
	logic [NUM_W-1:0]    nq_next;
	logic                last;

	// zero divisor makes every step subtract, so the quotient is all ones and saturates
	assign rem_shift = {rem_q, nq_q[NUM_W-1]};
	assign ge        = rem_shift >= {1'b0, den_q};
	assign diff      = rem_shift - {1'b0, den_q};
	assign rem_next  = ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
	assign nq_next   = {nq_q[NUM_W-2:0], ge};
	assign last      = step_q == STEP_W'(NUM_W - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: if (req.start) state_d = DIV_RUN;
			DIV_RUN:  if (last) state_d = DIV_IDLE;
			default:  state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DIV_RUN) && last;
			if (state_q == DIV_RUN) step_q <= step_q + 1'b1;
			else step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && req.start) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (state_q == DIV_RUN) begin
			nq_q  <= nq_next;
			rem_q <= rem_next;
			if (last) begin
				if (|nq_next[NUM_W-1:SPEED_W]) quot_q <= '1;
				else quot_q <= nq_next[SPEED_W-1:0];
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == DIV_IDLE)
		else $error("divider done while still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DIV_RUN && !last |=> state_q == DIV_RUN && !done_q)
		else $error("divider left run early");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DIV_IDLE && req.start |=> step_q == '0 && state_q == DIV_RUN)
		else $error("divider start not taken");

endmodule

// File: rtl/encoder_speed_direction_meter.sv
// encoder_speed_direction_meter: period-based speed and direction from timer events
// depends on esdm_pkg and esdm_divider
// overflow and capture events update the registered state when accepted; the window-closing A edge
// starts a 37-step serial division whose result loads into the m_tvalid register once that register is free
// throughput: one event per cycle while idle; a closing edge holds s_tready low until the result loads
// reset: arst_n clears all counters and stamps, loads register defaults 1000 and 86400000000
module encoder_speed_direction_meter import esdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// event stream in
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CAP_W-1:0]  s_tdata,   // [15:0] capture_value
	input  logic [1:0]        s_tuser,   // [1:0] kind
	// result stream out
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // [31:0] speed, [32] direction, [39:33] zero
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	main_state_t         state_q, state_d;
	logic [CNT_W-1:0]    period_q;
	logic [NUM_W-1:0]    numer_q;
	logic [CNT_W-1:0]    ovf_q;
	logic [CNT_W-1:0]    edge_q;
	logic [DEN_W-1:0]    first_q;
	logic [DEN_W-1:0]    second_q;
	logic [DEN_W-1:0]    b_q;
	logic                dir_q;
	logic                out_valid_q;
	logic [SPEED_W-1:0]  speed_q;
	logic                out_dir_q;

	logic                accept;
	kind_t               kind;
	logic [CNT_W-1:0]    ovf_inc;
	logic [CNT_W-1:0]    edge_inc;
	logic [DEN_W-1:0]    stamp;
	logic [DEN_W-1:0]    first_new;
	logic [DEN_W-1:0]    second_new;
	logic [CNT_W:0]      target;
	logic                close;
	logic [DEN_W-1:0]    elapsed;
	logic [DEN_W-1:0]    d_before;
	logic [DEN_W-1:0]    d_after;
	logic                out_free;
	logic                load_out;
	div_req_t            div_req;
	logic                div_done;
	logic [SPEED_W-1:0]  div_quot;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3]);
	assign prdata  = (cfg_idx == REG_NUMER) ? {{(CFG_W-NUM_W){1'b0}}, numer_q}
	                                         : {{(CFG_W-CNT_W){1'b0}}, period_q};

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);

	assign ovf_inc    = ovf_q + 1'b1;
	assign edge_inc   = edge_q + 1'b1;
	assign stamp      = {ovf_q, s_tdata};
	assign first_new  = (edge_inc == CNT_W'(2)) ? stamp : first_q;
	assign second_new = (edge_inc == CNT_W'(3)) ? stamp : second_q;
	assign target     = {1'b0, period_q} + (CNT_W+1)'(2);
	assign close      = accept && kind == KIND_A && edge_inc != CNT_W'(1)
	                    && {1'b0, edge_inc} == target;
	assign elapsed    = stamp - first_new;
	assign d_before   = b_q - first_new;
	assign d_after    = second_new - b_q;

	assign div_req.start = close;
	assign div_req.num   = numer_q;
	assign div_req.den   = elapsed;

	esdm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: if (close) state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= PERIOD_RST;
			numer_q     <= NUMER_RST;
			ovf_q       <= '0;
			edge_q      <= '0;
			first_q     <= '0;
			second_q    <= '0;
			b_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_PERIOD: period_q <= pwdata[CNT_W-1:0];
					REG_NUMER:  numer_q  <= pwdata[NUM_W-1:0];
					default: ;
				endcase
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (accept) begin
				case (kind)
					KIND_OVF: begin
						// count stays at zero until measuring has started
						if (ovf_inc == CNT_W'(1) && edge_q <= CNT_W'(1)) ovf_q <= '0;
						else ovf_q <= ovf_inc;
					end
					KIND_A: begin
						if (edge_inc == CNT_W'(1)) begin
							ovf_q  <= '0;
							edge_q <= edge_inc;
						end else begin
							first_q  <= first_new;
							second_q <= second_new;
							if (close) begin
								ovf_q  <= '0;
								edge_q <= '0;
							end else begin
								edge_q <= edge_inc;
							end
						end
					end
					KIND_B: if (edge_q == CNT_W'(2)) b_q <= stamp;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close) dir_q <= !(d_before < d_after);
		if (load_out) begin
			speed_q   <= div_quot;
			out_dir_q <= dir_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-SPEED_W-1){1'b0}}, out_dir_q, speed_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		close |=> state_q == ST_DIV && !s_tready)
		else $error("closing edge did not start the division");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("division finished outside the divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DIV || $past(state_q) == ST_HOLD)
		else $error("result raised without a finished division");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD |-> out_valid_q)
		else $error("result held back with output register empty");

endmodule

// File: test/esdm_speed_checker.sv
`timescale 1ns / 1ps
// esdm_speed_checker: watches the event, result and register ports of the meter,
// predicts every speed and direction transfer and compares it; needs esdm_pkg
module esdm_speed_checker import esdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [CAP_W-1:0]  s_tdata,   // [15:0] capture_value
	input  logic [1:0]        s_tuser,   // [1:0] kind
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,   // [31:0] speed, [32] direction, [39:33] zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	input  logic              run_done,
	output int                errors,
	output int unsigned       outstanding,
	output logic [CNT_W-1:0]  window_edges
);

	localparam int REG_SHIFT = 3;   // registers sit 8 bytes apart

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               direction;
	} speed_rec_t;

	logic [CNT_W-1:0] cfg_periods;
	logic [NUM_W-1:0] cfg_numer;
	logic [CNT_W-1:0] ovf_count;
	logic [CNT_W-1:0] edge_count;
	logic [DEN_W-1:0] a2_stamp;
	logic [DEN_W-1:0] a3_stamp;
	logic [DEN_W-1:0] b_stamp;
	speed_rec_t       speed_q[$];
	speed_rec_t       want;
	int               fail_count = 0;
	logic             closed = 1'b0;

	assign errors = fail_count;

	function automatic void take_event(input kind_t kind, input logic [CAP_W-1:0] cap);
		logic [DEN_W-1:0] stamp;
		logic [DEN_W-1:0] elapsed;
		logic [DEN_W-1:0] d_early;
		logic [DEN_W-1:0] d_late;
		logic [63:0]      quot;
		speed_rec_t       rec;
		case (kind)
			KIND_OVF: begin
				ovf_count = ovf_count + 1'b1;
				// overflows before the second A edge never count
				if (ovf_count == 1 && edge_count <= 1)
					ovf_count = '0;
			end
			KIND_A: begin
				edge_count = edge_count + 1'b1;
				if (edge_count == 1) begin
					ovf_count = '0;
				end else begin
					stamp = {ovf_count, cap};
					if (edge_count == 2)
						a2_stamp = stamp;
					else if (edge_count == 3)
						a3_stamp = stamp;
					if (32'(edge_count) == 32'(cfg_periods) + 32'd2) begin
						elapsed = stamp - a2_stamp;
						d_early = b_stamp - a2_stamp;
						d_late  = a3_stamp - b_stamp;
						if (elapsed == '0) begin
							rec.speed = '1;
						end else begin
							quot = 64'(cfg_numer) / 64'(elapsed);
							rec.speed = (quot > 64'hFFFF_FFFF) ? '1 : quot[SPEED_W-1:0];
						end
						rec.direction = (d_early < d_late) ? 1'b0 : 1'b1;
						speed_q.push_back(rec);
						ovf_count  = '0;
						edge_count = '0;
					end
				end
			end
			KIND_B: begin
				if (edge_count == 2)
					b_stamp = {ovf_count, cap};
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_periods = PERIOD_RST;
			cfg_numer   = NUMER_RST;
			ovf_count   = '0;
			edge_count  = '0;
			a2_stamp    = '0;
			a3_stamp    = '0;
			b_stamp     = '0;
			speed_q.delete();
			outstanding  <= 0;
			window_edges <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[REG_SHIFT]))
					REG_PERIOD: cfg_periods = pwdata[CNT_W-1:0];
					REG_NUMER:  cfg_numer = pwdata[NUM_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (speed_q.size() == 0) begin
					$error("unexpected result transfer: speed %0d direction %0d",
						m_tdata[SPEED_W-1:0], m_tdata[SPEED_W]);
					fail_count++;
				end else begin
					want = speed_q.pop_front();
					if (m_tdata[SPEED_W-1:0] !== want.speed) begin
						$error("speed: expected %0d, actual %0d",
							want.speed, m_tdata[SPEED_W-1:0]);
						fail_count++;
					end
					if (m_tdata[SPEED_W] !== want.direction) begin
						$error("direction: expected %0d, actual %0d",
							want.direction, m_tdata[SPEED_W]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				take_event(kind_t'(s_tuser), s_tdata);
			if (run_done && !closed) begin
				closed = 1'b1;
				if (speed_q.size() != 0) begin
					$error("speed: %0d expected transfers never arrived", speed_q.size());
					fail_count++;
				end
			end
			outstanding  <= speed_q.size();
			window_edges <= edge_count;
		end
	end

endmodule

// File: test/encoder_speed_direction_meter_tb.sv
`timescale 1ns / 1ps
// encoder_speed_direction_meter_tb: timer event stimulus, register setup and verdict
// needs esdm_pkg, encoder_speed_direction_meter and esdm_speed_checker
module encoder_speed_direction_meter_tb;
	import esdm_pkg::*;

	localparam int               RESET_CYCLES = 11;
	localparam int               DRAIN_CYCLES = 48;   // serial division plus margin
	localparam int               QUIET_LIMIT  = 4000;
	localparam int               REG_SHIFT    = 3;
	localparam int               PHASES       = 8;
	localparam int               PHASE_ITEMS  = 270;
	localparam int               LONG_ITEMS   = 40;
	localparam int               PERIOD_MAX   = 65533;
	localparam longint unsigned  TIMER_WRAP   = 65536;
	localparam logic [NUM_W-1:0] NUMER_MAX    = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CAP_W-1:0]  s_tdata = '0;    // [15:0] capture_value
	logic [1:0]        s_tuser = '0;    // [1:0] kind
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;         // [31:0] speed, [32] direction, [39:33] zero
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_W-1:0]  pwdata = '0;
	logic [CFG_W-1:0]  prdata;
	logic              pready;
	logic              run_done = 1'b0;
	int                errors;
	int unsigned       outstanding;
	logic [CNT_W-1:0]  window_edges;

	int                idle_pct = 0;
	int                stall_pct = 0;
	int unsigned       sent_items = 0;
	int unsigned       quiet_cycles = 0;
	logic [CAP_W-1:0]  timer_now = '0;

	// a numerator of zero in this table means a random one
	int unsigned       phase_period [PHASES] = '{1, 2, 4, PERIOD_MAX, 3, 7, 1, 12};
	logic [NUM_W-1:0]  phase_numer [PHASES] =
		'{NUMER_MAX, 37'd1, NUMER_RST, 37'd72000000, 37'd0, NUMER_MAX, 37'd0, 37'd5000};

	always #2 clk = ~clk;

	encoder_speed_direction_meter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	esdm_speed_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.run_done     (run_done),
		.errors       (errors),
		.outstanding  (outstanding),
		.window_edges (window_edges)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send(input kind_t kind, input logic [CAP_W-1:0] cap);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= cap;
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_NONE)
			sent_items++;
	endtask

	// wait for every expected result, then for the divider to go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(int'(idx) << REG_SHIFT);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input logic [CNT_W-1:0] period, input logic [NUM_W-1:0] numer);
		if (32'(window_edges) > 32'(period) + 32'd1) begin
			// a target below the running count is never met, so close this window first
			cfg_write(REG_PERIOD, CFG_W'(window_edges - 1'b1));
			send(KIND_A, 16'($urandom));
			drain();
		end
		cfg_write(REG_PERIOD, CFG_W'(period));
		cfg_write(REG_NUMER, CFG_W'(numer));
	endtask

	function automatic longint unsigned pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return $urandom_range(0, 3);
		else if (pick < 70)
			return $urandom_range(1, 3000);
		return $urandom_range(3000, 140000);
	endfunction

	// free-running 16-bit timer: overflow transfers precede each capture that wraps it
	task automatic tick(input longint unsigned gap, input kind_t kind);
		longint unsigned total;
		total = longint'(timer_now) + gap;
		while (total >= TIMER_WRAP) begin
			send(KIND_OVF, 16'($urandom));
			total -= TIMER_WRAP;
		end
		timer_now = CAP_W'(total);
		send(kind, timer_now);
	endtask

	initial begin
		int               pick;
		int unsigned      stop_at;
		logic [NUM_W-1:0] numer;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: idle events, first edge, stamps at the counter extremes
		send(KIND_NONE, 16'hFFFF);
		send(KIND_OVF, 16'h0000);
		send(KIND_B, 16'hFFFF);
		send(KIND_A, 16'h1234);
		send(KIND_OVF, 16'h5555);
		send(KIND_OVF, 16'hAAAA);
		send(KIND_A, 16'h0000);
		send(KIND_OVF, 16'hFFFF);
		send(KIND_B, 16'hFFFF);
		send(KIND_B, 16'h0000);
		send(KIND_A, 16'hFFFF);
		send(KIND_NONE, 16'h0000);
		drain();

		// zero elapsed time, then a quotient too wide for 32 bits
		set_window(16'd1, NUMER_MAX);
		send(KIND_A, 16'h0100);
		send(KIND_A, 16'h0100);
		send(KIND_A, 16'h0100);
		send(KIND_A, 16'h0000);
		send(KIND_A, 16'd10);
		send(KIND_A, 16'd20);
		drain();

		set_window(16'd1, 37'd1);
		send(KIND_A, 16'h0000);
		send(KIND_A, 16'd5);
		send(KIND_B, 16'd6);
		send(KIND_A, 16'hFFFF);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			numer = phase_numer[ph];
			if (numer == '0)
				numer = {5'($urandom), 32'($urandom)} | 37'd1;
			set_window(CNT_W'(phase_period[ph]), numer);
			stop_at = sent_items + ((phase_period[ph] == PERIOD_MAX) ? LONG_ITEMS : PHASE_ITEMS);
			while (sent_items < stop_at) begin
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					tick(pick_gap(), KIND_A);
					tick(pick_gap(), KIND_B);
				end else if (pick < 92) begin
					tick(pick_gap(), KIND_A);
				end else begin
					send(kind_t'($urandom_range(0, 3)), 16'($urandom));
				end
			end
			drain();
		end

		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
